// File: sv/iirdf1_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package iirdf1_pkg;

    localparam int SAMP_W  = 16;
    localparam int COEF_W  = 24;
    localparam int FRAC_W  = 20;
    localparam int PROD_W  = SAMP_W + COEF_W;
    localparam int ACC_W   = PROD_W + 4;
    localparam int NCOEF   = 13;
    localparam int STEP_W  = 4;
    localparam int CSEL_W  = 4;
    localparam int TAP_W   = 3;
    localparam int PDATA_W = 64;
    localparam int PADDR_W = 6;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_B0_B1 = 3'd0;
    localparam logic [2:0] REG_B2_B3 = 3'd1;
    localparam logic [2:0] REG_B4_B5 = 3'd2;
    localparam logic [2:0] REG_B6_A1 = 3'd3;
    localparam logic [2:0] REG_A2_A3 = 3'd4;
    localparam logic [2:0] REG_A4_A5 = 3'd5;
    localparam logic [2:0] REG_A6    = 3'd6;

    // Multiplier operand sources
    localparam logic [1:0] SRC_NONE = 2'd0;
    localparam logic [1:0] SRC_X    = 2'd1;
    localparam logic [1:0] SRC_XH   = 2'd2;
    localparam logic [1:0] SRC_YH   = 2'd3;

    // Program landmarks
    localparam logic [STEP_W-1:0] STEP_FIRST_A = 4'd7;
    localparam logic [STEP_W-1:0] STEP_DRAIN   = 4'd13;
    localparam logic [STEP_W-1:0] STEP_ROUND   = 4'd14;

    typedef logic signed [SAMP_W-1:0] samp_t;
    typedef logic signed [COEF_W-1:0] coef_t;

    typedef struct packed {
        logic              mul_en;
        logic              sub;
        logic [1:0]        src;
        logic [CSEL_W-1:0] coef;
        logic [TAP_W-1:0]  tap;
        logic              jmp_ge;
        logic [STEP_W-1:0] target;
        logic              last;
    } ctrl_word_t;

    typedef struct packed {
        logic clear;
        logic issue;
        logic sub;
    } mac_ctrl_t;

    function automatic ctrl_word_t mac_word(input logic [CSEL_W-1:0] coef,
                                            input logic [TAP_W-1:0]  tap,
                                            input logic [1:0]        src,
                                            input logic              sub,
                                            input logic              cond,
                                            input logic [STEP_W-1:0] target);
        ctrl_word_t w;
        w        = '0;
        w.mul_en = 1'b1;
        w.sub    = sub;
        w.src    = src;
        w.coef   = coef;
        w.tap    = tap;
        w.jmp_ge = cond;
        w.target = target;
        return w;
    endfunction

    // Microcode: b0*x, b1..b6 against input history, a1..a6 against output
    // history; a tap at or past the tap count jumps over the rest of its group.
    function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        w = '0;
        case (step)
            4'd0:  w = mac_word(4'd0,  3'd0, SRC_X,  1'b0, 1'b0, '0);
            4'd1:  w = mac_word(4'd1,  3'd1, SRC_XH, 1'b0, 1'b1, STEP_FIRST_A);
            4'd2:  w = mac_word(4'd2,  3'd2, SRC_XH, 1'b0, 1'b1, STEP_FIRST_A);
            4'd3:  w = mac_word(4'd3,  3'd3, SRC_XH, 1'b0, 1'b1, STEP_FIRST_A);
            4'd4:  w = mac_word(4'd4,  3'd4, SRC_XH, 1'b0, 1'b1, STEP_FIRST_A);
            4'd5:  w = mac_word(4'd5,  3'd5, SRC_XH, 1'b0, 1'b1, STEP_FIRST_A);
            4'd6:  w = mac_word(4'd6,  3'd6, SRC_XH, 1'b0, 1'b1, STEP_FIRST_A);
            4'd7:  w = mac_word(4'd7,  3'd1, SRC_YH, 1'b1, 1'b1, STEP_DRAIN);
            4'd8:  w = mac_word(4'd8,  3'd2, SRC_YH, 1'b1, 1'b1, STEP_DRAIN);
            4'd9:  w = mac_word(4'd9,  3'd3, SRC_YH, 1'b1, 1'b1, STEP_DRAIN);
            4'd10: w = mac_word(4'd10, 3'd4, SRC_YH, 1'b1, 1'b1, STEP_DRAIN);
            4'd11: w = mac_word(4'd11, 3'd5, SRC_YH, 1'b1, 1'b1, STEP_DRAIN);
            4'd12: w = mac_word(4'd12, 3'd6, SRC_YH, 1'b1, 1'b1, STEP_DRAIN);
            4'd13: w = '0;
            default: begin
                w      = '0;
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: sv/iirdf1_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module iirdf1_mac
    import iirdf1_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire mac_ctrl_t ctrl,
    input  wire coef_t     coef,
    input  wire samp_t     operand,
    output samp_t          y_sat
);

    localparam int SAT_LSB = FRAC_W + SAMP_W - 1;
    localparam logic signed [ACC_W-1:0] HALF =
        {{(ACC_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic                     prod_sub_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  rnd;
    logic                     ovf;

    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb begin
        acc_next = acc_reg;
        if (prod_vld_reg) begin
            acc_next = prod_sub_reg ? acc_reg - prod_ext : acc_reg + prod_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= ctrl.issue;
        end
        prod_reg     <= coef * operand;
        prod_sub_reg <= ctrl.sub;
        acc_reg      <= ctrl.clear ? '0 : acc_next;
    end

    // Round half up, then saturate when the bits above the result are not
    // all copies of the sign.
    assign rnd = acc_reg + HALF;
    assign ovf = !((&rnd[ACC_W-1:SAT_LSB]) || !(|rnd[ACC_W-1:SAT_LSB]));

    always_comb begin
        if (ovf) begin
            y_sat = rnd[ACC_W-1] ? {1'b1, {(SAMP_W-1){1'b0}}} : {1'b0, {(SAMP_W-1){1'b1}}};
        end else begin
            y_sat = rnd[SAT_LSB:FRAC_W];
        end
    end

endmodule

`default_nettype wire

// File: sv/iir_direct_form_one_filter.sv
// Order-6 direct form I IIR filter, Q1.15 samples, Q4.20 coefficients.
// Input stream: s_tdata carries one sample per item, s_tuser marks the start
// of a block; with it set, all past inputs and outputs count as zero.
// Output stream: m_tdata carries one rounded, saturated Q1.15 sample per item.
// Coefficients are loaded over APB (64-bit data, registers at 8*i) only while
// the filter is idle; the user ensures it, not the block. They reset to zero.
// A microcode program runs one multiply-accumulate step per cycle through a
// single shared 24x16 multiplier: 2*TAPS-1 product steps, the skip steps at
// the group ends, one drain step and one rounding step. The result becomes
// valid on the same edge that s_tready rises, so the filter takes no new item
// until the previous one has left its rounding step.
// The finished result sits in an output register, so the next item is taken
// while it waits. If the receiver stalls, the next item runs up to its
// rounding step and holds there until the output register frees up.
// Reset clears the histories, the coefficients and m_tvalid, and holds
// s_tready low while it lasts.
`timescale 1ns / 1ps
`default_nettype none

module iir_direct_form_one_filter
    import iirdf1_pkg::*;
#(
    parameter int TAPS = 7
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // input stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [15:0]        s_tdata,   // [15:0] sample_in
    input  wire logic [0:0]         s_tuser,   // [0] start_of_block
    // output stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [15:0]             m_tdata,   // [15:0] filtered_out
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    localparam int HIST = TAPS - 1;
    localparam int HIST_IW = (HIST > 1) ? $clog2(HIST) : 1;
    localparam logic [TAP_W:0] TAPS_L = (TAP_W+1)'(TAPS);
    localparam logic [TAP_W:0] HIST_L = (TAP_W+1)'(HIST);

    // coefficient file: b0..b6 then a1..a6
    coef_t coef_reg [NCOEF];

    samp_t xh_reg [HIST];
    samp_t yh_reg [HIST];
    samp_t x_reg;

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic              out_vld_reg;
    samp_t             out_reg;

    ctrl_word_t        cw;
    logic              take_jump;
    logic              accept;
    logic              out_free;
    logic              finish;
    logic [TAP_W-1:0]  hidx;
    logic              hidx_ok;
    samp_t             operand;
    samp_t             y_sat;
    mac_ctrl_t         mctl;
    logic              wr;
    logic [2:0]        ridx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign ridx   = paddr[PADDR_W-1:3];

    // Register writes: 48-bit registers of two coefficients; REG_A6 holds a6.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NCOEF; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (wr) begin
            case (ridx)
                REG_B0_B1: begin
                    coef_reg[0] <= pwdata[23:0];
                    coef_reg[1] <= pwdata[47:24];
                end
                REG_B2_B3: begin
                    coef_reg[2] <= pwdata[23:0];
                    coef_reg[3] <= pwdata[47:24];
                end
                REG_B4_B5: begin
                    coef_reg[4] <= pwdata[23:0];
                    coef_reg[5] <= pwdata[47:24];
                end
                REG_B6_A1: begin
                    coef_reg[6] <= pwdata[23:0];
                    coef_reg[7] <= pwdata[47:24];
                end
                REG_A2_A3: begin
                    coef_reg[8] <= pwdata[23:0];
                    coef_reg[9] <= pwdata[47:24];
                end
                REG_A4_A5: begin
                    coef_reg[10] <= pwdata[23:0];
                    coef_reg[11] <= pwdata[47:24];
                end
                REG_A6: begin
                    coef_reg[12] <= pwdata[23:0];
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            REG_B0_B1: prdata = {16'd0, coef_reg[1],  coef_reg[0]};
            REG_B2_B3: prdata = {16'd0, coef_reg[3],  coef_reg[2]};
            REG_B4_B5: prdata = {16'd0, coef_reg[5],  coef_reg[4]};
            REG_B6_A1: prdata = {16'd0, coef_reg[7],  coef_reg[6]};
            REG_A2_A3: prdata = {16'd0, coef_reg[9],  coef_reg[8]};
            REG_A4_A5: prdata = {16'd0, coef_reg[11], coef_reg[10]};
            REG_A6:    prdata = {40'd0, coef_reg[12]};
            default:   prdata = '0;
        endcase
    end

    // Sequencer: fetch the control word for this step. A tap at or past the
    // configured count skips to the next group instead of multiplying.
    assign cw        = ucode_rom(step_reg);
    assign take_jump = cw.jmp_ge && ({1'b0, cw.tap} >= TAPS_L);
    assign out_free  = !out_vld_reg || m_tready;
    assign finish    = busy_reg && cw.last && out_free;
    assign accept    = s_tvalid && s_tready;
    // hold off the input while reset is asserted
    assign s_tready  = aresetn && !busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (accept) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end else if (busy_reg) begin
            if (cw.last) begin
                // hold on the rounding step until the output register frees
                if (out_free) begin
                    busy_reg <= 1'b0;
                    step_reg <= '0;
                end
            end else begin
                step_reg <= take_jump ? cw.target : step_reg + 1'b1;
            end
        end
    end

    // Operand select: current sample or one history slot.
    assign hidx    = cw.tap - 1'b1;
    assign hidx_ok = {1'b0, hidx} < HIST_L;

    always_comb begin
        operand = '0;
        case (cw.src)
            SRC_X:   operand = x_reg;
            SRC_XH:  operand = hidx_ok ? xh_reg[hidx[HIST_IW-1:0]] : '0;
            SRC_YH:  operand = hidx_ok ? yh_reg[hidx[HIST_IW-1:0]] : '0;
            default: operand = '0;
        endcase
    end

    assign mctl.clear = accept;
    assign mctl.issue = busy_reg && cw.mul_en && !take_jump;
    assign mctl.sub   = cw.sub;

    iirdf1_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mctl),
        .coef    (coef_reg[cw.coef]),
        .operand (operand),
        .y_sat   (y_sat)
    );

    // Histories: drop them at a block start, advance them when a result
    // leaves the rounding step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HIST; i++) begin
                xh_reg[i] <= '0;
                yh_reg[i] <= '0;
            end
        end else if (accept && s_tuser[0]) begin
            for (int i = 0; i < HIST; i++) begin
                xh_reg[i] <= '0;
                yh_reg[i] <= '0;
            end
        end else if (finish) begin
            for (int i = HIST - 1; i > 0; i--) begin
                xh_reg[i] <= xh_reg[i-1];
                yh_reg[i] <= yh_reg[i-1];
            end
            xh_reg[0] <= x_reg;
            yh_reg[0] <= y_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg <= s_tdata;
        end
        if (finish) begin
            out_reg <= y_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (finish) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

endmodule

`default_nettype wire
